/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MPPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MPPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mppt_pkg.sv */
package mppt_pkg;

  // Widths of the stream fields.
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned COORD_BITS     = 12;
  localparam int unsigned COUNT_BITS     = 32;
  localparam int unsigned CFG_INDEX_BITS = 2;

  // Internal width of the tracked positions.
  localparam int unsigned POSITION_BITS = 12;

  // Signed width that holds a position plus or minus a 9-bit move.
  localparam int unsigned SUM_BITS =
    ((POSITION_BITS > COORD_BITS) ? POSITION_BITS : COORD_BITS) + 2;

  // Sign bits of the two moves inside the status byte.
  localparam int unsigned X_SIGN_BIT = 4;
  localparam int unsigned Y_SIGN_BIT = 5;

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [BYTE_BITS-1:0]     byte_t;

  localparam coord_t MAX_X_RESET = COORD_BITS'(1279);
  localparam coord_t MAX_Y_RESET = COORD_BITS'(719);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MAX_X = 2'd0,
    CFG_MAX_Y = 2'd1
  } cfg_index_e;

  // Position of the next byte within a packet.
  typedef enum logic [1:0] {
    BYTE_STATUS = 2'd0,
    BYTE_X_MOVE = 2'd1,
    BYTE_Y_MOVE = 2'd2
  } byte_index_e;

  typedef struct packed {
    coord_t max_x;
    coord_t max_y;
  } cfg_t;

  typedef struct packed {
    count_t byte_count;
    logic   packet_done;
    coord_t pos_y;
    coord_t pos_x;
  } result_t;

endpackage

/* rtl/mppt_core.sv */
module mppt_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  mppt_pkg::byte_t  byte_i,
  input  mppt_pkg::cfg_t   cfg_i,
  output mppt_pkg::result_t result_o
);

  // Adds or subtracts a signed move to a position and clamps to zero and the maximum.
  function automatic mppt_pkg::pos_t clamp_pos(input mppt_pkg::pos_t pos,
                                               input logic [8:0] move,
                                               input logic subtract,
                                               input mppt_pkg::coord_t maxv);
    logic signed [mppt_pkg::SUM_BITS-1:0] base;
    logic signed [mppt_pkg::SUM_BITS-1:0] mv;
    logic signed [mppt_pkg::SUM_BITS-1:0] sum;
    logic signed [mppt_pkg::SUM_BITS-1:0] top;
    logic signed [mppt_pkg::SUM_BITS-1:0] lim;
    base = $signed({{(mppt_pkg::SUM_BITS - mppt_pkg::POSITION_BITS){1'b0}}, pos});
    mv   = $signed({{(mppt_pkg::SUM_BITS - 9){move[8]}}, move});
    sum  = subtract ? (base - mv) : (base + mv);
    top  = $signed({{(mppt_pkg::SUM_BITS - mppt_pkg::COORD_BITS){1'b0}}, maxv});
    lim  = $signed({{(mppt_pkg::SUM_BITS - mppt_pkg::POSITION_BITS){1'b0}},
                    {mppt_pkg::POSITION_BITS{1'b1}}});
    if (top > lim) begin
      top = lim;
    end
    if (sum[mppt_pkg::SUM_BITS-1]) begin
      sum = '0;
    end else if (sum > top) begin
      sum = top;
    end
    return sum[mppt_pkg::POSITION_BITS-1:0];
  endfunction

  // Reports a position masked to the output field width.
  function automatic mppt_pkg::coord_t to_coord(input mppt_pkg::pos_t pos);
    logic [mppt_pkg::SUM_BITS-1:0] ext;
    ext = {{(mppt_pkg::SUM_BITS - mppt_pkg::POSITION_BITS){1'b0}}, pos};
    return ext[mppt_pkg::COORD_BITS-1:0];
  endfunction

  mppt_pkg::byte_index_e index_q, index_d;
  mppt_pkg::byte_t       status_q, status_d;
  mppt_pkg::byte_t       x_move_q, x_move_d;
  mppt_pkg::pos_t        x_pos_q, x_pos_d;
  mppt_pkg::pos_t        y_pos_q, y_pos_d;
  mppt_pkg::count_t      count_q, count_d;
  logic                  done;

  // Next packet state for the byte at the input.
  always_comb begin
    index_d  = index_q;
    status_d = status_q;
    x_move_d = x_move_q;
    x_pos_d  = x_pos_q;
    y_pos_d  = y_pos_q;
    count_d  = mppt_pkg::COUNT_BITS'(count_q + 1'b1);
    done     = 1'b0;
    case (index_q)
      mppt_pkg::BYTE_X_MOVE: begin
        x_move_d = byte_i;
        index_d  = mppt_pkg::BYTE_Y_MOVE;
      end
      mppt_pkg::BYTE_Y_MOVE: begin
        x_pos_d = clamp_pos(x_pos_q, {status_q[mppt_pkg::X_SIGN_BIT], x_move_q},
                            1'b0, cfg_i.max_x);
        y_pos_d = clamp_pos(y_pos_q, {status_q[mppt_pkg::Y_SIGN_BIT], byte_i},
                            1'b1, cfg_i.max_y);
        index_d = mppt_pkg::BYTE_STATUS;
        done    = 1'b1;
      end
      default: begin
        // A stray index value is taken as the start of a packet.
        status_d = byte_i;
        index_d  = mppt_pkg::BYTE_X_MOVE;
      end
    endcase
  end

  // Result for the byte at the input.
  always_comb begin
    result_o.pos_x       = to_coord(x_pos_d);
    result_o.pos_y       = to_coord(y_pos_d);
    result_o.packet_done = done;
    result_o.byte_count  = count_d;
  end

  // Packet state advances once per byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q  <= mppt_pkg::BYTE_STATUS;
      status_q <= '0;
      x_move_q <= '0;
      x_pos_q  <= '0;
      y_pos_q  <= '0;
      count_q  <= '0;
    end else if (step_i) begin
      index_q  <= index_d;
      status_q <= status_d;
      x_move_q <= x_move_d;
      x_pos_q  <= x_pos_d;
      y_pos_q  <= y_pos_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/mouse_packet_position_tracker.sv */
// Pointer position tracker for three-byte mouse packets. Each request on the slave
// stream carries one packet byte and yields exactly one request on the master stream
// with the current X and Y positions, a flag that is set when that byte completed a
// packet, and the running byte count. On the third byte of a packet the signed X move
// is added to X, the signed Y move is subtracted from Y (zero is the top), and both are
// clamped to zero and to max_x and max_y. A byte is taken every clock cycle while the
// master side keeps taking results. One input register and one result register sit
// around a single add-and-clamp pass: a byte is held in the input register, and its
// result is registered in the result register before it is offered on the master
// stream. Write max_x and max_y only while no byte is in flight; a write to any other
// index is dropped.
`include "assert_macros.svh"

module mouse_packet_position_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream from the device.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
  // Position results.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [11:0] pos_x, [23:12] pos_y, [55:24] byte_count
  output logic        m_axis_tuser,   // [0] packet_done
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [mppt_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [mppt_pkg::COORD_BITS-1:0]     cfg_data_i
);

  logic              in_valid_q, in_valid_d;
  mppt_pkg::byte_t   in_byte_q;
  logic              out_valid_q, out_valid_d;
  mppt_pkg::result_t out_q;
  mppt_pkg::result_t result;
  mppt_pkg::cfg_t    cfg_q, cfg_d;
  logic              s_accept;
  logic              out_free;
  logic              step;

  // Handshake: the input register moves on when the result register is free.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (mppt_pkg::cfg_index_e'(cfg_index_i))
        mppt_pkg::CFG_MAX_X: cfg_d.max_x = cfg_data_i;
        mppt_pkg::CFG_MAX_Y: cfg_d.max_y = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q.max_x <= mppt_pkg::MAX_X_RESET;
      cfg_q.max_y <= mppt_pkg::MAX_Y_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata;
    end
    if (step) begin
      out_q <= result;
    end
  end

  mppt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.byte_count, out_q.pos_y, out_q.pos_x};
  assign m_axis_tuser  = out_q.packet_done;

  // A byte waiting in the input register is neither lost nor changed.
  `MPPT_ASSERT_NXT(a_in_hold, in_valid_q && !step, in_valid_q && $stable(in_byte_q),
                   "input byte dropped while stalled")

  // A completed packet reports positions within the configured limits.
  `MPPT_ASSERT_IMP(a_pos_clamped, m_axis_tvalid && m_axis_tuser,
                   (out_q.pos_x <= cfg_q.max_x) && (out_q.pos_y <= cfg_q.max_y),
                   "position beyond configured maximum")

  // Two packets can never complete on consecutive bytes.
  `MPPT_ASSERT_NXT(a_done_spacing, step && result.packet_done,
                   !(step && result.packet_done),
                   "packet completed on back-to-back bytes")

endmodule
